>>> design/matrix_multiply_4x4_assert.svh
// Assertion macros shared by the matrix multiply RTL.
`ifndef MATRIX_MULTIPLY_4X4_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_ASSERT_SVH

`ifndef ASSERT_OFF
// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define MM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define MM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/mm4_pkg.sv
// Shared types and constants for the matrix multiply block.
`timescale 1ns / 1ps
package mm4_pkg;

    localparam int DATA_W = 32;   // element and product width
    localparam int PROD_W = 64;   // full product width
    localparam int IDX_W  = 2;    // row / column output width

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_RUN
    } t_state;

    // Travels with each MAC operation down the pipe.
    typedef struct packed {
        logic             first;  // first term of a dot product
        logic             last;   // last term of a dot product
        logic             fin;    // last term of the whole matrix
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

endpackage

>>> design/mm4_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> design/mm4_mac.sv
// Multiply, shift, accumulate and saturate path for one dot product at a time.
`timescale 1ns / 1ps
module mm4_mac #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  mm4_pkg::t_tag                         i_tag,
    input  logic signed [mm4_pkg::DATA_W-1:0]     i_a,
    input  logic signed [mm4_pkg::DATA_W-1:0]     i_b,
    output logic                                  o_strobe,
    output logic signed [mm4_pkg::DATA_W-1:0]     o_product,
    output logic [mm4_pkg::IDX_W-1:0]             o_row,
    output logic [mm4_pkg::IDX_W-1:0]             o_column,
    output logic                                  o_final_res
);

    import mm4_pkg::*;

    // Sum of DIM full-width terms never overflows this.
    localparam int ACW = PROD_W + $clog2(DIM);

    logic signed [PROD_W-1:0] w_mul;
    logic signed [PROD_W-1:0] w_shift;
    logic signed [ACW-1:0]    w_term;
    logic signed [ACW-1:0]    n_acc;
    logic                     w_sat_hi;
    logic                     w_sat_lo;
    logic [DATA_W-1:0]        w_sat;

    logic                     r_pvld;
    t_tag                     r_ptag;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_done;
    t_tag                     r_dtag;
    logic signed [ACW-1:0]    r_acc;

    assign w_mul   = i_a * i_b;
    assign w_shift = r_prod >>> FRAC_BITS;
    assign w_term  = ACW'(w_shift);
    assign n_acc   = r_ptag.first ? w_term : r_acc + w_term;

    // Clamp when the bits above bit 31 are not a plain sign extension.
    assign w_sat_hi = !r_acc[ACW-1] && (|r_acc[ACW-2:DATA_W-1]);
    assign w_sat_lo =  r_acc[ACW-1] && !(&r_acc[ACW-2:DATA_W-1]);

    always_comb begin
        priority if (w_sat_hi) begin
            w_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (w_sat_lo) begin
            w_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_sat = r_acc[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld   <= 1'b0;
            r_done   <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_pvld   <= i_vld;
            r_done   <= r_pvld && r_ptag.last;
            o_strobe <= r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptag <= i_tag;
        r_prod <= w_mul;
        if (r_pvld) begin
            r_acc  <= n_acc;
            r_dtag <= r_ptag;
        end
        o_product   <= w_sat;
        o_row       <= r_dtag.row;
        o_column    <= r_dtag.col;
        o_final_res <= r_dtag.fin;
    end

endmodule

>>> design/matrix_multiply_4x4.sv
// Top level: streaming DIM x DIM signed fixed-point matrix multiplier.
// Operation: A and B load one element per transfer; after the last B
//   transfer busy is high while the single shared MAC unit sweeps i, j and
//   k, and one result is presented per dot product. Start is ignored while
//   busy is high, so the next product loads only after all MACs are issued.
// Reset: synchronous, active low; clears load count, sequencer and strobes.
`timescale 1ns / 1ps
`include "matrix_multiply_4x4_assert.svh"
module matrix_multiply_4x4 #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [mm4_pkg::DATA_W-1:0] i_element,
    output logic                              o_strobe,
    output logic signed [mm4_pkg::DATA_W-1:0] o_product,
    output logic [mm4_pkg::IDX_W-1:0]         o_row,
    output logic [mm4_pkg::IDX_W-1:0]         o_column,
    output logic                              o_final_res
);

    import mm4_pkg::*;

    localparam int CELLS = DIM * DIM;
    localparam int AW    = $clog2(CELLS);       // store address
    localparam int CW    = $clog2(2 * CELLS);   // load count, 0 .. 2*CELLS-1
    localparam int DW    = $clog2(DIM);         // i / j / k counters

    // ------------------------------------------------------------------
    // Sequencer state.
    //   ST_LOAD: element transfers are taken and written to the A or B store.
    //   ST_RUN : one MAC is issued per cycle, k fastest, then j, then i.
    // ------------------------------------------------------------------
    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [DW-1:0]  r_i, n_i;
    logic [DW-1:0]  r_j, n_j;
    logic [DW-1:0]  r_k, n_k;

    logic           w_accept;
    logic           w_issue;
    logic           w_to_a;
    logic           w_we_a;
    logic           w_we_b;
    logic [AW-1:0]  w_waddr_a;
    logic [AW-1:0]  w_waddr_b;
    logic [AW-1:0]  w_raddr_a;
    logic [AW-1:0]  w_raddr_b;
    logic           w_k_end;
    logic           w_j_end;
    logic           w_i_end;
    t_tag           w_tag;

    // RAM read data arrives in the cycle after the address; the tag is registered alongside it.
    logic           r_rd_vld;
    t_tag           r_rd_tag;

    logic [DATA_W-1:0] w_rdata_a;
    logic [DATA_W-1:0] w_rdata_b;

    // Compute runs only from the stores; a new A may stream in while the
    // MAC pipe drains, since all reads have been issued by then.
    assign busy     = (r_state == ST_RUN);
    assign w_accept = start && !busy;

    assign w_to_a    = (r_count < CW'(CELLS));
    assign w_we_a    = w_accept && w_to_a;
    assign w_we_b    = w_accept && !w_to_a;
    assign w_waddr_a = r_count[AW-1:0];
    assign w_waddr_b = AW'(r_count - CW'(CELLS));

    // A[i][k] and B[k][j], row-major.
    assign w_raddr_a = AW'(AW'(r_i) * AW'(DIM) + AW'(r_k));
    assign w_raddr_b = AW'(AW'(r_k) * AW'(DIM) + AW'(r_j));

    assign w_k_end = (r_k == DW'(DIM - 1));
    assign w_j_end = (r_j == DW'(DIM - 1));
    assign w_i_end = (r_i == DW'(DIM - 1));

    always_comb begin
        w_tag.first = (r_k == '0);
        w_tag.last  = w_k_end;
        w_tag.fin   = w_k_end && w_j_end && w_i_end;
        w_tag.row   = IDX_W'(r_i);   // low bits only for larger DIM
        w_tag.col   = IDX_W'(r_j);
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        w_issue = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (r_count == CW'(2 * CELLS - 1)) begin
                        // last B element: start the product
                        n_count = '0;
                        n_state = ST_RUN;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            ST_RUN: begin
                w_issue = 1'b1;
                // counters wrap back to zero at the end of the sweep
                n_k = w_k_end ? '0 : r_k + 1'b1;
                if (w_k_end) begin
                    n_j = w_j_end ? '0 : r_j + 1'b1;
                    if (w_j_end) begin
                        n_i = w_i_end ? '0 : r_i + 1'b1;
                        if (w_i_end) begin
                            n_state = ST_LOAD;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_rd_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tag <= w_tag;
    end

    // ------------------------------------------------------------------
    // Element stores: A and B, one write port each (load), one read port
    // each (compute). Loads and reads never overlap in time.
    // ------------------------------------------------------------------
    mm4_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_left_store (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr_a),
        .i_wdata (i_element),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    mm4_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_right_store (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr_b),
        .i_wdata (i_element),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    // ------------------------------------------------------------------
    // Shared MAC: multiply, shift by FRAC_BITS, accumulate DIM terms,
    // saturate to 32 bits and present one result transfer per dot product.
    // ------------------------------------------------------------------
    mm4_mac #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (r_rd_vld),
        .i_tag       (r_rd_tag),
        .i_a         (w_rdata_a),
        .i_b         (w_rdata_b),
        .o_strobe    (o_strobe),
        .o_product   (o_product),
        .o_row       (o_row),
        .o_column    (o_column),
        .o_final_res (o_final_res)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `MM_ASSERT_SAME(a_final_idx, i_clk, i_rst_n, o_strobe && o_final_res, (o_row == IDX_W'(DIM - 1)) && (o_column == IDX_W'(DIM - 1)))
    `MM_ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, o_strobe, !o_strobe)
    `MM_ASSERT_SAME(a_run_no_write, i_clk, i_rst_n, busy, !w_we_a && !w_we_b)
    `MM_ASSERT_SAME(a_run_count_zero, i_clk, i_rst_n, $rose(busy), (r_count == '0) && (r_i == '0) && (r_j == '0) && (r_k == '0))

endmodule
